[hw/rtl/link_quality_table_oldest_replace_macros.svh]
// Assertion macros used by the link quality table top level.
`ifndef LINK_QUALITY_TABLE_OLDEST_REPLACE_MACROS_SVH
`define LINK_QUALITY_TABLE_OLDEST_REPLACE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LQT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("link quality table check failed");

// The consequent must hold in the cycle after the antecedent.
`define LQT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("link quality table check failed");

`endif

[hw/rtl/lqt_pkg.sv]
// Shared types, widths and codes of the link quality table.
`default_nettype none
package lqt_pkg;

	localparam int unsigned ENTRIES_DEF   = 8;
	localparam int unsigned TIME_BITS_DEF = 48;

	localparam int unsigned ID_W   = 32;
	localparam int unsigned RSSI_W = 9;
	localparam int unsigned SNR_W  = 8;
	localparam int unsigned NOW_W  = 48;
	localparam int unsigned SLOT_W = 3;

	typedef logic [1:0] outcome_t;
	localparam outcome_t OUT_MATCH   = 2'd0;
	localparam outcome_t OUT_FILL    = 2'd1;
	localparam outcome_t OUT_REPLACE = 2'd2;
	localparam outcome_t OUT_IGNORED = 2'd3;

	// Control part of the search record that moves down the row of cells.
	typedef struct packed {
		logic valid;
		logic found;
		logic matched;
		logic have_old;
	} scan_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/lqt_if.sv]
// Handshake interfaces for report items and result items.
`default_nettype none
interface lqt_rpt_if;
	import lqt_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [ID_W-1:0]          radio_id;
	logic signed [RSSI_W-1:0] rssi_dbm;
	logic signed [SNR_W-1:0]  snr_quarter_db;
	logic [NOW_W-1:0]         now_ms;
	modport source (output valid, radio_id, rssi_dbm, snr_quarter_db, now_ms, input ready);
	modport sink (input valid, radio_id, rssi_dbm, snr_quarter_db, now_ms, output ready);
endinterface

interface lqt_res_if;
	import lqt_pkg::*;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot;
	logic [1:0]        outcome;
	logic [ID_W-1:0]   evicted_id;
	modport source (output valid, slot, outcome, evicted_id, input ready);
	modport sink (input valid, slot, outcome, evicted_id, output ready);
endinterface
`default_nettype wire

[hw/rtl/lqt_cell.sv]
// One table entry with its stage of the search that runs down the row.
`default_nettype none
module lqt_cell #(
	parameter int unsigned ENTRIES   = 8,
	parameter int unsigned TIME_BITS = 48,
	parameter int unsigned IDX       = 0
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire  logic [lqt_pkg::ID_W-1:0]          id,
	input  wire  lqt_pkg::scan_ctl_t                ctl_in,
	input  wire  logic [$clog2(ENTRIES)-1:0]        sel_in,
	input  wire  logic [$clog2(ENTRIES)-1:0]        old_idx_in,
	input  wire  logic [TIME_BITS-1:0]              old_time_in,
	input  wire  logic [lqt_pkg::ID_W-1:0]          old_radio_in,
	output lqt_pkg::scan_ctl_t                      ctl_out,
	output logic [$clog2(ENTRIES)-1:0]              sel_out,
	output logic [$clog2(ENTRIES)-1:0]              old_idx_out,
	output logic [TIME_BITS-1:0]                    old_time_out,
	output logic [lqt_pkg::ID_W-1:0]                old_radio_out,
	input  wire                                     wr_en,
	input  wire  logic [$clog2(ENTRIES)-1:0]        wr_idx,
	input  wire  logic [lqt_pkg::ID_W-1:0]          wr_radio,
	input  wire  logic [TIME_BITS-1:0]              wr_time,
	input  wire  logic signed [lqt_pkg::RSSI_W-1:0] wr_rssi,
	input  wire  logic signed [lqt_pkg::SNR_W-1:0]  wr_snr
);
	import lqt_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic                     valid_q;
	logic [ID_W-1:0]          radio_q;
	logic [TIME_BITS-1:0]     time_q;
	logic signed [RSSI_W-1:0] rssi_q;
	logic signed [SNR_W-1:0]  snr_q;

	scan_ctl_t            ctl_n;
	logic [IDX_W-1:0]     sel_n;
	logic [IDX_W-1:0]     old_idx_n;
	logic [TIME_BITS-1:0] old_time_n;
	logic [ID_W-1:0]      old_radio_n;
	logic                 hit;
	logic                 older;
	logic                 wr_here;

	assign hit     = !valid_q || (radio_q == id);
	assign older   = !ctl_in.have_old || (time_q < old_time_in);
	assign wr_here = wr_en && (wr_idx == MY_IDX);

	always_comb begin
		ctl_n       = ctl_in;
		sel_n       = sel_in;
		old_idx_n   = old_idx_in;
		old_time_n  = old_time_in;
		old_radio_n = old_radio_in;
		if (!ctl_in.found && hit) begin
			ctl_n.found   = 1'b1;
			ctl_n.matched = valid_q;
			sel_n         = MY_IDX;
		end
		if (older) begin
			ctl_n.have_old = 1'b1;
			old_idx_n      = MY_IDX;
			old_time_n     = time_q;
			old_radio_n    = radio_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
			valid_q <= 1'b0;
		end else begin
			ctl_out <= ctl_n;
			if (wr_here) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sel_out       <= sel_n;
		old_idx_out   <= old_idx_n;
		old_time_out  <= old_time_n;
		old_radio_out <= old_radio_n;
		if (wr_here) begin
			radio_q <= wr_radio;
			time_q  <= wr_time;
			rssi_q  <= wr_rssi;
			snr_q   <= wr_snr;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/link_quality_table_oldest_replace.sv]
// Top level of the link quality table with oldest-entry replacement.
//
//   Channel  Dir  Handshake          Carries
//   rpt      in   valid/ready        radio_id, rssi_dbm, snr_quarter_db, now_ms
//   res      out  valid/ready        slot, outcome, evicted_id
//   cfg      in   cfg_we             cfg_wdata (tracking enable)
//
// One item is in flight at a time: after acceptance the search record walks the row
// of cells one cell per cycle, the final record is registered, and the result is then
// written to the output register; the next item is taken once the block is idle again.
// A finished result waits in the output register while the next item is taken.
// Reset clears all entries to empty and sets tracking enabled.
// A stalled result holds the final write until the output register is free.
`default_nettype none
`include "link_quality_table_oldest_replace_macros.svh"
module link_quality_table_oldest_replace #(
	parameter int unsigned ENTRIES   = lqt_pkg::ENTRIES_DEF,
	parameter int unsigned TIME_BITS = lqt_pkg::TIME_BITS_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	lqt_rpt_if.sink   rpt,
	lqt_res_if.source res,
	input  wire       cfg_we,
	input  wire       cfg_wdata
);
	import lqt_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t state_q;
	logic   enable_q;
	logic   start_q;

	logic [ID_W-1:0]          id_q;
	logic signed [RSSI_W-1:0] rssi_q;
	logic signed [SNR_W-1:0]  snr_q;
	logic [TIME_BITS-1:0]     now_q;
	logic [63:0]              now_wide;

	scan_ctl_t            tok_ctl       [ENTRIES+1];
	logic [IDX_W-1:0]     tok_sel       [ENTRIES+1];
	logic [IDX_W-1:0]     tok_old_idx   [ENTRIES+1];
	logic [TIME_BITS-1:0] tok_old_time  [ENTRIES+1];
	logic [ID_W-1:0]      tok_old_radio [ENTRIES+1];

	logic             fin_found_q;
	logic             fin_matched_q;
	logic [IDX_W-1:0] fin_sel_q;
	logic [IDX_W-1:0] fin_old_idx_q;
	logic [ID_W-1:0]  fin_old_radio_q;

	logic              res_valid_q;
	logic [SLOT_W-1:0] slot_q;
	outcome_t          outcome_q;
	logic [ID_W-1:0]   evicted_q;

	logic             accept;
	logic             done;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       slot_wide;
	logic             last_valid;

	assign accept     = rpt.valid && rpt.ready;
	assign rpt.ready  = (state_q == ST_IDLE);
	assign now_wide   = {{(64 - NOW_W){1'b0}}, rpt.now_ms};
	assign last_valid = tok_ctl[ENTRIES].valid;
	assign done       = (state_q == ST_WRITE) && (!res_valid_q || res.ready);
	assign wr_en      = done && enable_q;
	assign wr_idx     = fin_found_q ? fin_sel_q : fin_old_idx_q;
	assign slot_wide  = {{(8 - IDX_W){1'b0}}, wr_idx};

	assign tok_ctl[0]       = '{valid: start_q, found: 1'b0, matched: 1'b0, have_old: 1'b0};
	assign tok_sel[0]       = '0;
	assign tok_old_idx[0]   = '0;
	assign tok_old_time[0]  = '0;
	assign tok_old_radio[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lqt_cell #(
			.ENTRIES   (ENTRIES),
			.TIME_BITS (TIME_BITS),
			.IDX       (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.id            (id_q),
			.ctl_in        (tok_ctl[i]),
			.sel_in        (tok_sel[i]),
			.old_idx_in    (tok_old_idx[i]),
			.old_time_in   (tok_old_time[i]),
			.old_radio_in  (tok_old_radio[i]),
			.ctl_out       (tok_ctl[i+1]),
			.sel_out       (tok_sel[i+1]),
			.old_idx_out   (tok_old_idx[i+1]),
			.old_time_out  (tok_old_time[i+1]),
			.old_radio_out (tok_old_radio[i+1]),
			.wr_en         (wr_en),
			.wr_idx        (wr_idx),
			.wr_radio      (id_q),
			.wr_time       (now_q),
			.wr_rssi       (rssi_q),
			.wr_snr        (snr_q)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enable_q    <= 1'b1;
			start_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_valid) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (done) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= rpt.radio_id;
			rssi_q <= rpt.rssi_dbm;
			snr_q  <= rpt.snr_quarter_db;
			now_q  <= now_wide[TIME_BITS-1:0];
		end
		if (last_valid) begin
			fin_found_q     <= tok_ctl[ENTRIES].found;
			fin_matched_q   <= tok_ctl[ENTRIES].matched;
			fin_sel_q       <= tok_sel[ENTRIES];
			fin_old_idx_q   <= tok_old_idx[ENTRIES];
			fin_old_radio_q <= tok_old_radio[ENTRIES];
		end
		if (done) begin
			priority if (!enable_q) begin
				slot_q    <= '0;
				outcome_q <= OUT_IGNORED;
				evicted_q <= '0;
			end else if (fin_found_q) begin
				slot_q    <= slot_wide[SLOT_W-1:0];
				outcome_q <= fin_matched_q ? OUT_MATCH : OUT_FILL;
				evicted_q <= '0;
			end else begin
				slot_q    <= slot_wide[SLOT_W-1:0];
				outcome_q <= OUT_REPLACE;
				evicted_q <= fin_old_radio_q;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.slot       = slot_q;
	assign res.outcome    = outcome_q;
	assign res.evicted_id = evicted_q;

	`LQT_ASSERT_SAME(a_idle_no_token, clk, arst_n, state_q == ST_IDLE, !last_valid && !start_q)
	`LQT_ASSERT_SAME(a_token_in_scan, clk, arst_n, last_valid, state_q == ST_SCAN)
	`LQT_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, start_q && state_q == ST_SCAN)
	`LQT_ASSERT_SAME(a_evict_only_replace, clk, arst_n,
		res_valid_q && outcome_q != OUT_REPLACE, evicted_q == '0)

endmodule
`default_nettype wire
